// File: rtl/adaptive_spike_threshold_assert.svh
// Assertion macros for the adaptive spike threshold block.
// Included by the RTL module that carries concurrent checks; no other dependency.
`ifndef ADAPTIVE_SPIKE_THRESHOLD_ASSERT_SVH
`define ADAPTIVE_SPIKE_THRESHOLD_ASSERT_SVH
`ifndef SYNTHESIS
// condition holds at every edge outside reset
`define AST_HOLD(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
// antecedent implies consequent in the next cycle
`define AST_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define AST_HOLD(lbl, cond, msg)
`define AST_NEXT(lbl, ante, cons, msg)
`endif
`endif

// File: rtl/ast_pkg.sv
// Package for the adaptive spike threshold block: sizes, reset values,
// channel record type and sequencer states. No dependencies.
`default_nettype none
package ast_pkg;
  localparam int NUM_CHANNELS = 64;
  localparam int CHUNKS       = 16;
  localparam int CH_AW  = $clog2(NUM_CHANNELS);
  localparam int IDX_W  = $clog2(CHUNKS);
  localparam int FILL_W = $clog2(CHUNKS + 1);
  localparam int SA_W   = $clog2(NUM_CHANNELS * CHUNKS);
  localparam int FLAT_LIMIT = CHUNKS / 2;

  localparam logic signed [15:0] RUN_MIN_RESET = 16'sh7fff;
  localparam logic signed [15:0] RUN_MAX_RESET = 16'sh8000;
  localparam logic [16:0] GAIN_ONE = 17'h10000;

  // configuration register indexes
  localparam logic CFG_GAIN = 1'b0;
  localparam logic CFG_RANK = 1'b1;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_PRESET = 1'b1;

  typedef struct packed {
    logic signed [15:0] run_min;
    logic signed [15:0] run_max;
    logic [FILL_W-1:0]  fill;
    logic [15:0]        flatc;
    logic signed [31:0] sl;
    logic signed [31:0] sh;
  } chan_rec_t;

  localparam chan_rec_t REC_RESET = '{run_min: RUN_MIN_RESET, run_max: RUN_MAX_RESET,
                                      fill: '0, flatc: '0, sl: '0, sh: '0};

  typedef enum logic [3:0] {
    ST_IDLE, ST_LOAD, ST_PRESET, ST_DIV, ST_COPY_RD, ST_COPY_WR, ST_CHECK,
    ST_SEL_LD, ST_SEL_CMP, ST_MUL_H, ST_MUL_L, ST_ADD_L, ST_WB, ST_OUT
  } state_t;
endpackage
`default_nettype wire

// File: rtl/adaptive_spike_threshold.sv
// Adaptive spike threshold: per-channel chunk extremes, store and smoothing.
// Depends on ast_pkg and adaptive_spike_threshold_assert.svh.
//
// Each word is handled alone. A sample that does not end a chunk is accepted
// with a record read, then modified and written back; a preset writes its
// record, then sweeps writes over its store entries. A chunk end that copies
// an older pair adds a bit-serial remainder of random_pick over the fill
// count, then a store read; one that fills the store adds two read sweeps of
// the store memory for the order statistics and two shared multiplies. The
// per-channel record memory takes one access a cycle; the store memories
// each have a read and a write port. A result waits in the output register;
// a new word is accepted meanwhile, and the next chunk end holds until that
// register is free. No clearing pass after reset.
`default_nettype none
`include "adaptive_spike_threshold_assert.svh"
module adaptive_spike_threshold (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // channel[5:0], sample_value[21:6], random_pick[37:22],
  // preset_low[53:38], preset_high[69:54], zero[71:70]
  input  wire logic [71:0] s_tdata,
  // operation[0]
  input  wire logic        s_tuser,
  input  wire logic        s_tlast,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // out_channel[5:0], low_threshold[21:6], high_threshold[37:22], zero[39:38]
  output logic [39:0]      m_tdata,
  // updated[0], flat_chunk[1]
  output logic [1:0]       m_tuser,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [16:0] cfg_data
);
  localparam int CW = ast_pkg::CHUNKS;

  ast_pkg::state_t state, state_next;

  // configuration
  logic [16:0] gain;
  logic [3:0]  order_rank;
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      gain       <= ast_pkg::GAIN_ONE;
      order_rank <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        ast_pkg::CFG_GAIN: gain <= cfg_data;
        ast_pkg::CFG_RANK: order_rank <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // latched input word
  logic               op_r, end_r;
  logic [5:0]         ch_r;
  logic signed [15:0] samp_r, plo_r, phi_r;
  logic [15:0]        pick_r;
  logic               in_acc, in_drop;

  assign s_tready = (state == ast_pkg::ST_IDLE);
  assign in_acc   = s_tvalid && s_tready;
  assign in_drop  = {26'd0, s_tdata[5:0]} >= 32'(ast_pkg::NUM_CHANNELS);

  // channel record memory with per-channel valid bits
  ast_pkg::chan_rec_t chm [ast_pkg::NUM_CHANNELS];
  ast_pkg::chan_rec_t ch_rd, rec, wb_rec;
  logic [ast_pkg::NUM_CHANNELS-1:0] ch_valid;
  logic ch_v_r, chm_we;
  logic [ast_pkg::CH_AW-1:0] ch_a;
  assign ch_a = ch_r[ast_pkg::CH_AW-1:0];

  always_ff @(posedge clk) begin
    if (in_acc) ch_rd <= chm[s_tdata[ast_pkg::CH_AW-1:0]];
    if (chm_we) chm[ch_a] <= wb_rec;
  end
  always_ff @(posedge clk) begin
    if (rst) ch_valid <= '0;
    else if (chm_we) ch_valid[ch_a] <= 1'b1;
  end
  assign rec = ch_v_r ? ch_rd : ast_pkg::REC_RESET;

  // store memories
  logic signed [15:0] mx_mem [ast_pkg::NUM_CHANNELS * CW];
  logic signed [15:0] mn_mem [ast_pkg::NUM_CHANNELS * CW];
  logic signed [15:0] mx_rd, mn_rd, st_wmx, st_wmn;
  logic [ast_pkg::IDX_W-1:0] st_widx, st_ridx;
  logic [ast_pkg::SA_W-1:0]  st_wa, st_ra, st_base;
  logic st_we;
  assign st_base = ast_pkg::SA_W'(ch_a) * ast_pkg::SA_W'(CW);
  assign st_wa = st_base + ast_pkg::SA_W'(st_widx);
  assign st_ra = st_base + ast_pkg::SA_W'(st_ridx);
  always_ff @(posedge clk) begin
    mx_rd <= mx_mem[st_ra];
    mn_rd <= mn_mem[st_ra];
    if (st_we) begin
      mx_mem[st_wa] <= st_wmx;
      mn_mem[st_wa] <= st_wmn;
    end
  end

  // working registers
  logic signed [15:0] nmin, nmax, t_hi, t_lo;
  logic [ast_pkg::FILL_W-1:0] fill_r, fill_c, cnt;
  logic [15:0] flatc_r, flatc_c;
  logic flat_r, flat_c, copy_c, upd_r, found_hi, found_lo;
  logic signed [31:0] sl_r, sh_r;
  logic [3:0] rem;
  logic [4:0] rem_sh;
  logic signed [15:0] arr_mx [CW];
  logic signed [15:0] arr_mn [CW];
  logic signed [51:0] prod_r, prod_c;
  logic signed [33:0] diff_c;
  logic signed [35:0] delta;
  logic [16:0] g_eff;
  logic [ast_pkg::IDX_W-1:0] k_hi, k_lo;

  // running extremes and chunk-end decisions from the fetched record
  always_comb begin
    nmin = (samp_r < rec.run_min) ? samp_r : rec.run_min;
    nmax = (samp_r > rec.run_max) ? samp_r : rec.run_max;
    fill_c = (rec.fill > ast_pkg::FILL_W'(CW - 1)) ? ast_pkg::FILL_W'(CW - 1) : rec.fill;
    flat_c = !(nmax > nmin);
    flatc_c = (flat_c && rec.flatc != 16'hffff) ? rec.flatc + 16'd1 : rec.flatc;
    copy_c = flat_c && ({16'd0, flatc_c} >= 32'(ast_pkg::FLAT_LIMIT));
  end

  // remainder step, order-statistic ranks and gain clamp
  assign rem_sh = {rem, pick_r[15]};
  assign k_hi = ({28'd0, order_rank} > 32'(CW - 1)) ? ast_pkg::IDX_W'(CW - 1)
                                                    : ast_pkg::IDX_W'(order_rank);
  assign k_lo = ast_pkg::IDX_W'(CW - 1) - k_hi;
  assign g_eff = (gain > ast_pkg::GAIN_ONE) ? ast_pkg::GAIN_ONE : gain;

  // rank counts of the streamed candidate against the loaded entries
  logic [ast_pkg::FILL_W-1:0] lt_hi, le_hi, lt_lo, le_lo;
  logic hit_hi, hit_lo;
  always_comb begin
    lt_hi = '0; le_hi = '0; lt_lo = '0; le_lo = '0;
    for (int j = 0; j < CW; j++) begin
      lt_hi = lt_hi + ast_pkg::FILL_W'(arr_mx[j] < mx_rd);
      le_hi = le_hi + ast_pkg::FILL_W'(arr_mx[j] <= mx_rd);
      lt_lo = lt_lo + ast_pkg::FILL_W'(arr_mn[j] < mn_rd);
      le_lo = le_lo + ast_pkg::FILL_W'(arr_mn[j] <= mn_rd);
    end
    hit_hi = (lt_hi <= ast_pkg::FILL_W'(k_hi)) && (ast_pkg::FILL_W'(k_hi) < le_hi);
    hit_lo = (lt_lo <= ast_pkg::FILL_W'(k_lo)) && (ast_pkg::FILL_W'(k_lo) < le_lo);
  end

  // shared smoothing multiply and step
  always_comb begin
    if (state == ast_pkg::ST_MUL_H)
      diff_c = $signed({{2{t_hi[15]}}, t_hi, 16'd0}) - $signed({{2{sh_r[31]}}, sh_r});
    else
      diff_c = $signed({{2{t_lo[15]}}, t_lo, 16'd0}) - $signed({{2{sl_r[31]}}, sl_r});
    prod_c = diff_c * $signed({1'b0, g_eff});
    delta  = 36'((prod_r + 52'sd32768) >>> 16);
  end

  // sequencer: next state, memory ports
  always_comb begin
    state_next = state;
    chm_we  = 1'b0;
    wb_rec  = '{run_min: ast_pkg::RUN_MIN_RESET, run_max: ast_pkg::RUN_MAX_RESET,
                fill: fill_r, flatc: flatc_r, sl: sl_r, sh: sh_r};
    st_we   = 1'b0;
    st_widx = fill_c[ast_pkg::IDX_W-1:0];
    st_wmx  = nmax;
    st_wmn  = nmin;
    st_ridx = (state == ast_pkg::ST_COPY_RD) ? rem : cnt[ast_pkg::IDX_W-1:0];
    case (state)
      ast_pkg::ST_IDLE: if (in_acc && !in_drop) state_next = ast_pkg::ST_LOAD;
      ast_pkg::ST_LOAD: begin
        if (op_r == ast_pkg::OP_PRESET) begin
          chm_we = 1'b1;
          wb_rec = rec;
          wb_rec.sl = {plo_r, 16'd0};
          wb_rec.sh = {phi_r, 16'd0};
          state_next = ast_pkg::ST_PRESET;
        end else if (!end_r) begin
          chm_we = 1'b1;
          wb_rec = rec;
          wb_rec.run_min = nmin;
          wb_rec.run_max = nmax;
          state_next = ast_pkg::ST_IDLE;
        end else if (copy_c && fill_c != '0) begin
          state_next = ast_pkg::ST_DIV;
        end else begin
          st_we = !flat_c || copy_c;
          state_next = ast_pkg::ST_CHECK;
        end
      end
      ast_pkg::ST_PRESET: begin
        st_we   = 1'b1;
        st_widx = cnt[ast_pkg::IDX_W-1:0];
        st_wmx  = phi_r;
        st_wmn  = plo_r;
        if (cnt == ast_pkg::FILL_W'(CW - 1)) state_next = ast_pkg::ST_IDLE;
      end
      ast_pkg::ST_DIV: if (cnt == ast_pkg::FILL_W'(15)) state_next = ast_pkg::ST_COPY_RD;
      ast_pkg::ST_COPY_RD: state_next = ast_pkg::ST_COPY_WR;
      ast_pkg::ST_COPY_WR: begin
        st_we   = 1'b1;
        st_widx = fill_r[ast_pkg::IDX_W-1:0];
        st_wmx  = mx_rd;
        st_wmn  = mn_rd;
        state_next = ast_pkg::ST_CHECK;
      end
      ast_pkg::ST_CHECK:
        state_next = (fill_r >= ast_pkg::FILL_W'(CW)) ? ast_pkg::ST_SEL_LD : ast_pkg::ST_WB;
      ast_pkg::ST_SEL_LD: if (cnt == ast_pkg::FILL_W'(CW)) state_next = ast_pkg::ST_SEL_CMP;
      ast_pkg::ST_SEL_CMP: if (cnt == ast_pkg::FILL_W'(CW)) state_next = ast_pkg::ST_MUL_H;
      ast_pkg::ST_MUL_H: state_next = ast_pkg::ST_MUL_L;
      ast_pkg::ST_MUL_L: state_next = ast_pkg::ST_ADD_L;
      ast_pkg::ST_ADD_L: state_next = ast_pkg::ST_WB;
      ast_pkg::ST_WB: begin
        chm_we = 1'b1;
        state_next = ast_pkg::ST_OUT;
      end
      ast_pkg::ST_OUT: if (!m_tvalid || m_tready) state_next = ast_pkg::ST_IDLE;
      default: state_next = ast_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ast_pkg::ST_IDLE;
    else state <= state_next;
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ast_pkg::ST_IDLE: if (in_acc) begin
        op_r   <= s_tuser;
        end_r  <= s_tlast;
        ch_r   <= s_tdata[5:0];
        samp_r <= s_tdata[21:6];
        pick_r <= s_tdata[37:22];
        plo_r  <= s_tdata[53:38];
        phi_r  <= s_tdata[69:54];
        ch_v_r <= ch_valid[s_tdata[ast_pkg::CH_AW-1:0]];
      end
      ast_pkg::ST_LOAD: begin
        cnt     <= '0;
        rem     <= '0;
        flat_r  <= flat_c;
        flatc_r <= flatc_c;
        sl_r    <= rec.sl;
        sh_r    <= rec.sh;
        upd_r   <= 1'b0;
        fill_r  <= fill_c + ast_pkg::FILL_W'(!flat_c || (copy_c && fill_c == '0));
      end
      ast_pkg::ST_PRESET: cnt <= cnt + 1'b1;
      ast_pkg::ST_DIV: begin
        rem    <= (rem_sh >= 5'(fill_r)) ? 4'(rem_sh - 5'(fill_r)) : rem_sh[3:0];
        pick_r <= {pick_r[14:0], 1'b0};
        cnt    <= cnt + 1'b1;
      end
      ast_pkg::ST_COPY_WR: fill_r <= fill_r + 1'b1;
      ast_pkg::ST_CHECK: begin
        cnt      <= '0;
        found_hi <= 1'b0;
        found_lo <= 1'b0;
      end
      ast_pkg::ST_SEL_LD: begin
        if (cnt != '0) begin
          arr_mx[CW-1] <= mx_rd;
          arr_mn[CW-1] <= mn_rd;
          for (int i = 0; i < CW - 1; i++) begin
            arr_mx[i] <= arr_mx[i+1];
            arr_mn[i] <= arr_mn[i+1];
          end
        end
        cnt <= (cnt == ast_pkg::FILL_W'(CW)) ? '0 : cnt + 1'b1;
      end
      ast_pkg::ST_SEL_CMP: begin
        if (cnt != '0 && hit_hi) begin
          t_hi <= mx_rd;
          found_hi <= 1'b1;
        end
        if (cnt != '0 && hit_lo) begin
          t_lo <= mn_rd;
          found_lo <= 1'b1;
        end
        cnt <= cnt + 1'b1;
      end
      ast_pkg::ST_MUL_H: prod_r <= prod_c;
      ast_pkg::ST_MUL_L: begin
        sh_r   <= sh_r + delta[31:0];
        prod_r <= prod_c;
      end
      ast_pkg::ST_ADD_L: begin
        sl_r    <= sl_r + delta[31:0];
        fill_r  <= '0;
        flatc_r <= '0;
        upd_r   <= 1'b1;
      end
      default: ;
    endcase
  end

  // output register
  logic [32:0] rnd_lo, rnd_hi;
  assign rnd_lo = {sl_r[31], sl_r} + 33'd32768;
  assign rnd_hi = {sh_r[31], sh_r} + 33'd32768;
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ast_pkg::ST_OUT && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (state == ast_pkg::ST_OUT && (!m_tvalid || m_tready)) begin
      m_tdata <= {2'b00, rnd_hi[31:16], rnd_lo[31:16], ch_r};
      m_tuser <= {flat_r, upd_r};
    end
  end

  // checks
  `AST_NEXT(a_one_at_a_time, in_acc && !in_drop, !s_tready, "word accepted while busy")
  `AST_HOLD(a_rem_range, state != ast_pkg::ST_COPY_RD || 5'(rem) < 5'(fill_r),
            "copy source not below fill count")
  `AST_HOLD(a_sel_found, state != ast_pkg::ST_MUL_H || (found_hi && found_lo),
            "order statistic not found")
  `AST_HOLD(a_upd_full, state != ast_pkg::ST_WB || !upd_r || fill_r == '0,
            "update without restarting fill")
endmodule
`default_nettype wire

// File: test/adaptive_spike_threshold_checker.sv
// Checker for the adaptive spike threshold block: watches the input, config
// and result channels, predicts each result and compares. Depends on ast_pkg.
`default_nettype none
module adaptive_spike_threshold_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  input  wire logic        s_tready,
  input  wire logic [71:0] s_tdata,
  input  wire logic        s_tuser,
  input  wire logic        s_tlast,
  input  wire logic        m_tvalid,
  input  wire logic        m_tready,
  input  wire logic [39:0] m_tdata,
  input  wire logic [1:0]  m_tuser,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [16:0] cfg_data,
  output int               fail_count,
  output int               pending,
  output int               result_count,
  output int               update_count,
  output int               flat_count_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [5:0]         ch;
    logic signed [15:0] lo;
    logic signed [15:0] hi;
    logic               upd;
    logic               flat;
  } thr_word_t;

  // predicted block state
  logic [16:0]        gain_q;
  logic [3:0]         rank_q;
  logic signed [15:0] rmin [ast_pkg::NUM_CHANNELS];
  logic signed [15:0] rmax [ast_pkg::NUM_CHANNELS];
  logic signed [15:0] st_max [ast_pkg::NUM_CHANNELS][ast_pkg::CHUNKS];
  logic signed [15:0] st_min [ast_pkg::NUM_CHANNELS][ast_pkg::CHUNKS];
  int unsigned        fillc [ast_pkg::NUM_CHANNELS];
  int unsigned        flatc [ast_pkg::NUM_CHANNELS];
  logic signed [31:0] sm_lo [ast_pkg::NUM_CHANNELS];
  logic signed [31:0] sm_hi [ast_pkg::NUM_CHANNELS];
  thr_word_t          thr_q [$];

  function automatic logic signed [15:0] kth_smallest(
      logic signed [15:0] v [ast_pkg::CHUNKS], int k);
    logic signed [15:0] t [ast_pkg::CHUNKS];
    logic signed [15:0] x;
    t = v;
    for (int i = 1; i < ast_pkg::CHUNKS; i++) begin
      x = t[i];
      for (int j = i; j > 0 && t[j-1] > x; j--) begin
        t[j] = t[j-1];
        t[j-1] = x;
      end
    end
    return t[k];
  endfunction

  function automatic logic signed [31:0] move_toward(logic signed [31:0] s,
                                                      logic signed [15:0] tgt,
                                                      logic [16:0] g);
    longint diff;
    longint prod;
    diff = (longint'(tgt) <<< 16) - longint'(s);
    prod = diff * longint'(g) + 32768;
    return 32'(longint'(s) + (prod >>> 16));
  endfunction

  function automatic logic signed [15:0] round_thr(logic signed [31:0] s);
    longint r;
    r = (longint'(s) + 32768) >>> 16;
    return 16'(r);
  endfunction

  task automatic predict_word(logic op, logic [5:0] ch, logic signed [15:0] v,
                              logic last, logic [15:0] pick,
                              logic signed [15:0] plo, logic signed [15:0] phi);
    logic signed [15:0] cmin, cmax, tmax, tmin;
    int unsigned fill, k, src;
    logic [16:0] g;
    logic flat, upd;
    thr_word_t w;
    upd = 1'b0;
    if (op == ast_pkg::OP_PRESET) begin
      sm_lo[ch] = 32'(plo) <<< 16;
      sm_hi[ch] = 32'(phi) <<< 16;
      for (int i = 0; i < ast_pkg::CHUNKS; i++) begin
        st_min[ch][i] = plo;
        st_max[ch][i] = phi;
      end
      return;
    end
    if (v < rmin[ch]) rmin[ch] = v;
    if (v > rmax[ch]) rmax[ch] = v;
    if (!last) return;
    cmin = rmin[ch];
    cmax = rmax[ch];
    rmin[ch] = ast_pkg::RUN_MIN_RESET;
    rmax[ch] = ast_pkg::RUN_MAX_RESET;
    fill = (fillc[ch] > ast_pkg::CHUNKS - 1) ? ast_pkg::CHUNKS - 1 : fillc[ch];
    flat = !(cmax > cmin);
    if (!flat) begin
      st_max[ch][fill] = cmax;
      st_min[ch][fill] = cmin;
      fill++;
    end else begin
      if (flatc[ch] < 65535) flatc[ch]++;
      if (flatc[ch] >= ast_pkg::FLAT_LIMIT) begin
        if (fill > 0) begin
          src = pick % fill;
          st_max[ch][fill] = st_max[ch][src];
          st_min[ch][fill] = st_min[ch][src];
        end else begin
          st_max[ch][fill] = cmax;
          st_min[ch][fill] = cmin;
        end
        fill++;
      end
    end
    // store full: order statistics and smoothing step
    if (fill >= ast_pkg::CHUNKS) begin
      k = (rank_q > ast_pkg::CHUNKS - 1) ? ast_pkg::CHUNKS - 1 : rank_q;
      g = (gain_q > ast_pkg::GAIN_ONE) ? ast_pkg::GAIN_ONE : gain_q;
      tmax = kth_smallest(st_max[ch], k);
      tmin = kth_smallest(st_min[ch], ast_pkg::CHUNKS - 1 - k);
      sm_hi[ch] = move_toward(sm_hi[ch], tmax, g);
      sm_lo[ch] = move_toward(sm_lo[ch], tmin, g);
      fill = 0;
      flatc[ch] = 0;
      upd = 1'b1;
    end
    fillc[ch] = fill;
    w.ch = ch;
    w.lo = round_thr(sm_lo[ch]);
    w.hi = round_thr(sm_hi[ch]);
    w.upd = upd;
    w.flat = flat;
    thr_q.push_back(w);
  endtask

  assign pending = thr_q.size();

  always @(posedge clk) begin
    thr_word_t e;
    int errs;
    errs = 0;
    if (rst) begin
      gain_q <= ast_pkg::GAIN_ONE;
      rank_q <= '0;
      for (int c = 0; c < ast_pkg::NUM_CHANNELS; c++) begin
        rmin[c] = ast_pkg::RUN_MIN_RESET;
        rmax[c] = ast_pkg::RUN_MAX_RESET;
        fillc[c] = 0;
        flatc[c] = 0;
        sm_lo[c] = '0;
        sm_hi[c] = '0;
        for (int i = 0; i < ast_pkg::CHUNKS; i++) begin
          st_max[c][i] = '0;
          st_min[c][i] = '0;
        end
      end
      thr_q.delete();
      fail_count <= 0;
      result_count <= 0;
      update_count <= 0;
      flat_count_seen <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == ast_pkg::CFG_GAIN) gain_q <= cfg_data;
        else rank_q <= cfg_data[3:0];
      end
      // result side first: a word entering now cannot leave this cycle
      if (m_tvalid && m_tready) begin
        result_count <= result_count + 1;
        if (thr_q.size() == 0) begin
          $error("result word with nothing expected: %h %b", m_tdata, m_tuser);
          errs++;
        end else begin
          e = thr_q.pop_front();
          if (m_tdata[5:0] != e.ch) begin
            $error("out_channel: expected %0d actual %0d", e.ch, m_tdata[5:0]);
            errs++;
          end
          if ($signed(m_tdata[21:6]) != e.lo) begin
            $error("low_threshold: expected %0d actual %0d", e.lo,
                   $signed(m_tdata[21:6]));
            errs++;
          end
          if ($signed(m_tdata[37:22]) != e.hi) begin
            $error("high_threshold: expected %0d actual %0d", e.hi,
                   $signed(m_tdata[37:22]));
            errs++;
          end
          if (m_tuser[0] != e.upd) begin
            $error("updated: expected %0d actual %0d", e.upd, m_tuser[0]);
            errs++;
          end
          if (m_tuser[1] != e.flat) begin
            $error("flat_chunk: expected %0d actual %0d", e.flat, m_tuser[1]);
            errs++;
          end
          if (e.upd) update_count <= update_count + 1;
          if (e.flat) flat_count_seen <= flat_count_seen + 1;
        end
        fail_count <= fail_count + errs;
      end
      if (s_tvalid && s_tready)
        predict_word(s_tuser, s_tdata[5:0], s_tdata[21:6], s_tlast, s_tdata[37:22],
                     s_tdata[53:38], s_tdata[69:54]);
    end
  end
endmodule
`default_nettype wire

// File: test/tb_adaptive_spike_threshold.sv
// Testbench top for the adaptive spike threshold block: clock, reset,
// stimulus and verdict. Depends on ast_pkg and the checker module.
`default_nettype none
module tb_adaptive_spike_threshold;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG = 20000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [71:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [16:0] cfg_data = '0;

  int fail_count, pending, result_count, update_count, flat_seen;
  int idle_cycles = 0;
  int words_sent = 0;
  bit no_idle = 1'b0;
  bit hold_off = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  adaptive_spike_threshold uut (.*);

  adaptive_spike_threshold_checker chk (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser, .s_tlast,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser, .cfg_valid, .cfg_ready,
    .cfg_index, .cfg_data, .fail_count, .pending, .result_count,
    .update_count, .flat_count_seen(flat_seen)
  );

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    int n;
    @(posedge clk iff !rst);
    forever begin
      if (hold_off) begin
        m_tready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end else if (!no_idle && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 10);
        m_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // watchdog on cycles with no accepted word
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)
        || rst || hold_off)
      idle_cycles <= 0;
    else if (idle_cycles >= WATCHDOG) begin
      $display("Test completed with failures");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  task automatic send_word(logic op, logic [5:0] ch, logic [15:0] v, logic last,
                           logic [15:0] pick, logic [15:0] plo, logic [15:0] phi);
    int n;
    if (!no_idle && $urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 10);
      s_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tlast  <= last;
    s_tdata  <= {2'b00, phi, plo, pick, v, ch};
    @(posedge clk iff s_tready);
    words_sent++;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk iff pending == 0);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_cfg(logic idx, logic [16:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk iff cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // random sample with mostly small channel set to fill stores quickly
  task automatic random_sample(bit wide_ch);
    logic [5:0] ch;
    logic [15:0] v;
    ch = wide_ch ? 6'($urandom) : 6'($urandom_range(0, 3));
    v = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40) - 20);
    send_word(ast_pkg::OP_SAMPLE, ch, v, $urandom_range(0, 3) == 0, 16'($urandom),
              16'($urandom), 16'($urandom));
  endtask

  task automatic random_phase(int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 60) == 0)
        send_word(ast_pkg::OP_PRESET, 6'($urandom_range(0, 3)), 16'($urandom),
                  1'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      else if ($urandom_range(0, 12) == 0)
        // chunk end: a one-sample, flat chunk if the channel had no open chunk
        send_word(ast_pkg::OP_SAMPLE, 6'($urandom_range(0, 3)), 16'($urandom), 1'b1,
                  16'($urandom), 16'($urandom), 16'($urandom));
      else
        random_sample($urandom_range(0, 9) == 0);
    end
  endtask

  initial begin
    logic [16:0] gains [5];
    gains = '{17'd65536, 17'd1, 17'd0, 17'h1ffff, 17'd20000};
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_cfg(ast_pkg::CFG_GAIN, ast_pkg::GAIN_ONE);
    write_cfg(ast_pkg::CFG_RANK, 17'd0);

    // directed: extremes, presets, flat chunks, flat-limit copies on channel 63
    send_word(ast_pkg::OP_SAMPLE, 6'd0, 16'h8000, 1'b0, 16'hffff, 16'h0, 16'h0);
    send_word(ast_pkg::OP_SAMPLE, 6'd0, 16'h7fff, 1'b1, 16'h0, 16'h0, 16'h0);
    send_word(ast_pkg::OP_SAMPLE, 6'd1, 16'h1234, 1'b1, 16'h0, 16'h0, 16'h0);
    send_word(ast_pkg::OP_PRESET, 6'd2, 16'hffff, 1'b1, 16'hffff, 16'h8000, 16'h7fff);
    for (int i = 0; i < 9; i++)
      send_word(ast_pkg::OP_SAMPLE, 6'd2, 16'h0005, 1'b1, 16'($urandom), 16'h0, 16'h0);
    for (int i = 0; i < 10; i++)
      send_word(ast_pkg::OP_SAMPLE, 6'd63, 16'(i), 1'b1, 16'hffff, 16'hffff, 16'hffff);
    drain();

    // pressure: long receiver hold-off while sending
    hold_off = 1'b1;
    random_phase(200);
    drain();

    for (int p = 0; p < 5; p++) begin
      write_cfg(ast_pkg::CFG_GAIN, gains[p]);
      write_cfg(ast_pkg::CFG_RANK, (p == 3) ? 17'd15 : 17'($urandom_range(0, 15)));
      random_phase(300);
      drain();
    end
    no_idle = 1'b1;
    random_phase(250);
    drain();

    $display("Sent %0d words; %0d results, %0d threshold updates, %0d flat chunks.",
             words_sent, result_count, update_count, flat_seen);
    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end
endmodule
`default_nettype wire
